/* hw/rtl/fwht_pkg.sv */
package fwht_pkg;

	// Table geometry and defaults
	localparam int NUM_SETS_DEF = 1024;
	localparam int NUM_WAYS     = 4;
	localparam int WAY_W        = $clog2(NUM_WAYS);

	// Replacement scoring: a way from another generation gets this bonus
	localparam int OLD_GEN_BONUS = 1000;
	// Depth difference spans -255..255, plus the bonus: fits in 12 signed bits
	localparam int SCORE_W       = 12;

	// Generation counter limits
	localparam logic [7:0] GEN_FIRST = 8'd1;
	localparam logic [7:0] GEN_LAST  = 8'd255;

	// Stream data widths, padded to whole bytes
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 56;

	// Request codes
	typedef enum logic [1:0] {
		CMD_PROBE  = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_NEWGEN = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// One way of a set as it sits in the table memory
	typedef struct packed {
		logic [63:0]        key;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
		logic [1:0]         flag;
		logic [15:0]        move;
		logic [7:0]         gen;
	} way_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic upd_wr;
		logic clr_start;
		logic clr_wr;
		logic load_out;
		logic gen_step;
		logic gen_clear;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;
		logic clr_last;
	} dp_stat_t;

endpackage

/* hw/rtl/fwht_ram.sv */
module fwht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/fwht_ctrl.sv */
module fwht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fwht_pkg::cmd_t      in_cmd,
	output logic                in_ready,
	input  fwht_pkg::dp_stat_t  stat,
	output fwht_pkg::dp_cmd_t   cmd
);

	fwht_pkg::state_t state_q, state_d;
	fwht_pkg::cmd_t   item_cmd_q;
	logic             accept;

	assign accept = in_valid && in_ready;

	// State and request code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fwht_pkg::ST_CLEAR;
			item_cmd_q <= fwht_pkg::CMD_PROBE;
		end else begin
			state_q <= state_d;
			if (accept) begin
				item_cmd_q <= in_cmd;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fwht_pkg::ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = fwht_pkg::ST_IDLE;
				end
			end
			fwht_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (in_cmd) inside
						fwht_pkg::CMD_PROBE, fwht_pkg::CMD_STORE: state_d = fwht_pkg::ST_UPDATE;
						fwht_pkg::CMD_CLEAR:  state_d = fwht_pkg::ST_CLEAR;
						default:              state_d = fwht_pkg::ST_IDLE;
					endcase
				end
			end
			fwht_pkg::ST_UPDATE: begin
				if (item_cmd_q == fwht_pkg::CMD_STORE || stat.out_free) begin
					state_d = fwht_pkg::ST_IDLE;
				end
			end
			default: state_d = fwht_pkg::ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fwht_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			fwht_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_cmd) inside
						fwht_pkg::CMD_PROBE, fwht_pkg::CMD_STORE: begin
							cmd.capture = 1'b1;
							cmd.rd_en   = 1'b1;
						end
						fwht_pkg::CMD_NEWGEN: begin
							cmd.gen_step = 1'b1;
						end
						default: begin
							cmd.gen_clear = 1'b1;
							cmd.clr_start = 1'b1;
						end
					endcase
				end
			end
			fwht_pkg::ST_UPDATE: begin
				if (item_cmd_q == fwht_pkg::CMD_STORE) begin
					cmd.upd_wr = 1'b1;
				end else if (stat.out_free) begin
					cmd.load_out = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// A store finishes its write-back and returns to idle in the next cycle.
	a_store_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fwht_pkg::ST_UPDATE && item_cmd_q == fwht_pkg::CMD_STORE
		|=> state_q == fwht_pkg::ST_IDLE)
		else $error("store did not return to idle");

	// An accepted clear request starts the sweep.
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_cmd == fwht_pkg::CMD_CLEAR |=> state_q == fwht_pkg::ST_CLEAR)
		else $error("clear request did not start the sweep");

endmodule

/* hw/rtl/fwht_dp.sv */
module fwht_dp #(
	parameter int NUM_SETS = fwht_pkg::NUM_SETS_DEF,
	localparam int ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fwht_pkg::dp_cmd_t   cmd,
	output fwht_pkg::dp_stat_t  stat,
	input  logic [63:0]         in_key,
	input  logic signed [7:0]   in_depth,
	input  logic signed [15:0]  in_score,
	input  logic [1:0]          in_flag,
	input  logic [15:0]         in_move,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_hit,
	output logic signed [7:0]   out_depth,
	output logic signed [15:0]  out_score,
	output logic [1:0]          out_flag,
	output logic [15:0]         out_move,
	output logic [7:0]          out_generation
);

	localparam int NW     = fwht_pkg::NUM_WAYS;
	localparam int ROW_W  = $bits(fwht_pkg::way_t) * NW;
	localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'(NUM_SETS - 1);

	// Captured request
	logic [ADDR_W-1:0]  addr_q;
	logic [63:0]        key_q;
	logic signed [7:0]  depth_q;
	logic signed [15:0] score_q;
	logic [1:0]         flag_q;
	logic [15:0]        move_q;

	logic [7:0]         gen_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	// Result register
	logic               out_valid_q;
	logic               out_hit_q;
	logic signed [7:0]  out_depth_q;
	logic signed [15:0] out_score_q;
	logic [1:0]         out_flag_q;
	logic [15:0]        out_move_q;
	logic [7:0]         out_gen_q;

	// Memory interface
	fwht_pkg::way_t [NW-1:0] rd_row;
	fwht_pkg::way_t [NW-1:0] wr_row;
	fwht_pkg::way_t          new_way;
	logic                    ram_wr_en;
	logic [ADDR_W-1:0]       ram_wr_addr;
	logic [ROW_W-1:0]        ram_wr_data;
	logic [ADDR_W-1:0]       ram_rd_addr;
	logic [ROW_W-1:0]        ram_rd_data;

	// Lookup and replacement
	logic [NW-1:0]                       match;
	logic                                hit;
	logic [fwht_pkg::WAY_W-1:0]          hit_idx;
	logic [fwht_pkg::WAY_W-1:0]          victim;
	logic [fwht_pkg::WAY_W-1:0]          wr_way;
	logic signed [fwht_pkg::SCORE_W-1:0] rscore [NW];
	logic signed [fwht_pkg::SCORE_W-1:0] best_val;
	logic signed [9:0]                   diff [NW];

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q  <= in_key[ADDR_W-1:0] & SET_MASK;
			key_q   <= in_key;
			depth_q <= in_depth;
			score_q <= in_score;
			flag_q  <= in_flag;
			move_q  <= in_move;
		end
	end

	// Generation counter, wraps from its last value to the first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= fwht_pkg::GEN_FIRST;
		end else if (cmd.gen_clear) begin
			gen_q <= fwht_pkg::GEN_FIRST;
		end else if (cmd.gen_step) begin
			gen_q <= (gen_q == fwht_pkg::GEN_LAST) ? fwht_pkg::GEN_FIRST : gen_q + 8'd1;
		end
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	assign stat.clr_last = (clr_addr_q == SET_MASK);
	assign stat.out_free = !out_valid_q || out_ready;

	// Key match over the set, lowest way first
	always_comb begin
		hit_idx = '0;
		for (int w = 0; w < NW; w++) begin
			match[w] = (rd_row[w].key == key_q);
		end
		for (int w = NW - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_idx = fwht_pkg::WAY_W'(w);
			end
		end
		hit = |match;
	end

	// Replacement scores and victim choice; ties keep the lower way
	always_comb begin
		for (int w = 0; w < NW; w++) begin
			diff[w]   = 10'(depth_q) - 10'(rd_row[w].depth);
			rscore[w] = fwht_pkg::SCORE_W'(diff[w])
				+ ((rd_row[w].gen != gen_q) ? fwht_pkg::SCORE_W'(fwht_pkg::OLD_GEN_BONUS)
					: fwht_pkg::SCORE_W'(0));
		end
		victim   = '0;
		best_val = rscore[0];
		for (int w = 1; w < NW; w++) begin
			if (rscore[w] > best_val) begin
				best_val = rscore[w];
				victim   = fwht_pkg::WAY_W'(w);
			end
		end
	end

	// Write-back row: the chosen way takes the new entry
	always_comb begin
		new_way.key   = key_q;
		new_way.depth = depth_q;
		new_way.score = score_q;
		new_way.flag  = flag_q;
		new_way.move  = move_q;
		new_way.gen   = gen_q;
		wr_way        = hit ? hit_idx : victim;
		wr_row        = rd_row;
		wr_row[wr_way] = new_way;
	end

	assign rd_row      = ram_rd_data;
	assign ram_rd_addr = in_key[ADDR_W-1:0] & SET_MASK;
	assign ram_wr_en   = cmd.upd_wr | cmd.clr_wr;
	assign ram_wr_addr = cmd.clr_wr ? clr_addr_q : addr_q;
	assign ram_wr_data = cmd.clr_wr ? '0 : ROW_W'(wr_row);

	fwht_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result fields; a miss reports zeros
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit_q   <= hit;
			out_depth_q <= hit ? rd_row[hit_idx].depth : '0;
			out_score_q <= hit ? rd_row[hit_idx].score : '0;
			out_flag_q  <= hit ? rd_row[hit_idx].flag  : '0;
			out_move_q  <= hit ? rd_row[hit_idx].move  : '0;
			out_gen_q   <= hit ? rd_row[hit_idx].gen   : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_hit        = out_hit_q;
	assign out_depth      = out_depth_q;
	assign out_score      = out_score_q;
	assign out_flag       = out_flag_q;
	assign out_move       = out_move_q;
	assign out_generation = out_gen_q;

	// The result register is loaded only when it is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over an untaken result");

	// A loaded result is offered in the next cycle.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not offered");

	// The generation counter never holds zero.
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q != 8'd0)
		else $error("generation counter reached zero");

endmodule

/* hw/rtl/four_way_hash_table_with_aging_core.sv */
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  request: command, key, entry to store
// m_axis    out        m_axis_tvalid / m_axis_tready  probe result: hit flag, stored entry
//
// For a probe or store, the set is read from the single-port-write table memory while idle,
// then in the update state a probe loads the result register and a store writes the set back.
// A new-generation request steps the generation; a clear request resets it and sweeps the table.
// After reset the table is swept to zero, set by set, before the first request is taken.
// A probe waits in the update state while an earlier result is still untaken.
module four_way_hash_table_with_aging_core #(
	parameter int NUM_SETS = fwht_pkg::NUM_SETS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// key[63:0], search_depth[71:64], eval_score[87:72], bound_kind[89:88],
	// best_move[105:90], zero padding above
	input  logic [fwht_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_depth[7:0], out_score[23:8], out_flag[25:24], out_move[41:26],
	// out_generation[49:42], zero padding above
	output logic [fwht_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// hit[0]
	output logic                             m_axis_tuser
);

	fwht_pkg::dp_cmd_t  dp_cmd;
	fwht_pkg::dp_stat_t dp_stat;
	fwht_pkg::cmd_t     in_cmd;
	logic signed [7:0]  out_depth;
	logic signed [15:0] out_score;
	logic [1:0]         out_flag;
	logic [15:0]        out_move;
	logic [7:0]         out_generation;

	assign in_cmd = fwht_pkg::cmd_t'(s_axis_tuser);

	fwht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (in_cmd),
		.in_ready (s_axis_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	fwht_dp #(
		.NUM_SETS(NUM_SETS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.stat           (dp_stat),
		.in_key         (s_axis_tdata[63:0]),
		.in_depth       (s_axis_tdata[71:64]),
		.in_score       (s_axis_tdata[87:72]),
		.in_flag        (s_axis_tdata[89:88]),
		.in_move        (s_axis_tdata[105:90]),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_hit        (m_axis_tuser),
		.out_depth      (out_depth),
		.out_score      (out_score),
		.out_flag       (out_flag),
		.out_move       (out_move),
		.out_generation (out_generation)
	);

	// Pack the result fields, lowest field first
	assign m_axis_tdata = {6'd0, out_generation, out_move, out_flag, out_score, out_depth};

endmodule
